// ----- rtl/ttw_pkg.sv -----
`default_nettype none

package ttw_pkg;

	// default window geometry
	localparam int unsigned LINES_DEF   = 6;
	localparam int unsigned COLUMNS_DEF = 21;

	// line width register after reset
	localparam logic [4:0] LINE_WIDTH_RST = 5'd21;

	// depth of the queue between front and back
	localparam int unsigned QDEPTH = 2;

	// character codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	// request kinds
	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	// one classified transaction as held in the queue
	typedef struct packed {
		req_t       req;
		logic [7:0] rx_byte;
		logic [2:0] read_row;
		logic [4:0] read_col;
		logic       is_letter;
		logic       is_lbr;
		logic       is_print;
		logic       is_break;
	} item_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_break(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ttw_ram.sv -----
`default_nettype none

module ttw_ram #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 126
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ttw_front.sv -----
`default_nettype none

module ttw_front (
	input  wire logic          req_type,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [2:0]    read_row,
	input  wire logic [4:0]    read_col,
	output ttw_pkg::item_t     item
);

	// classify the incoming byte once, so the back only selects
	always_comb begin
		item.req       = ttw_pkg::req_t'(req_type);
		item.rx_byte   = rx_byte;
		item.read_row  = read_row;
		item.read_col  = read_col;
		item.is_letter = ttw_pkg::is_letter(rx_byte);
		item.is_lbr    = (rx_byte == ttw_pkg::CH_LBR);
		item.is_print  = (rx_byte >= ttw_pkg::CH_SPACE) && (rx_byte <= ttw_pkg::CH_TILDE);
		item.is_break  = ttw_pkg::is_break(rx_byte);
	end

endmodule

`default_nettype wire

// ----- rtl/ttw_queue.sv -----
`default_nettype none

module ttw_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ttw_pkg::item_t   push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output ttw_pkg::item_t        head
);

	localparam int unsigned QAW = $clog2(ttw_pkg::QDEPTH);
	localparam int unsigned QCW = $clog2(ttw_pkg::QDEPTH + 1);

	ttw_pkg::item_t  mem_q [ttw_pkg::QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;

	assign full  = (count_q == QCW'(ttw_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(ttw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(ttw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ttw_back.sv -----
`default_nettype none

module ttw_back #(
	parameter int unsigned LINES   = ttw_pkg::LINES_DEF,
	parameter int unsigned COLUMNS = ttw_pkg::COLUMNS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [4:0]    line_width,
	input  wire logic          q_empty,
	input  wire ttw_pkg::item_t it,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [6:0]         read_char,
	output logic               read_valid,
	output logic [2:0]         cursor_row,
	output logic [4:0]         cursor_len,
	output logic               char_stored,
	output logic               line_advanced,
	output logic               scrolled,
	output logic               in_escape
);

	localparam int unsigned RW = $clog2(LINES);
	localparam int unsigned LW = $clog2(COLUMNS + 1);
	localparam int unsigned AW = $clog2(LINES * COLUMNS);
	localparam int unsigned CW = LW + 5;
	localparam int unsigned XW = RW + 3;

	// window state
	logic [RW-1:0] top_q;
	logic [RW-1:0] cur_slot_q;
	logic [RW-1:0] cursor_q;
	logic [LW-1:0] cur_len_q;
	logic          esc_q;
	logic [7:0]    prev_q;
	logic [LW-1:0] len_q [LINES];

	// output register
	logic          out_valid_q;
	logic          rvalid_q;
	logic [2:0]    crow_q;
	logic [4:0]    clen_q;
	logic          stored_q;
	logic          adv_q;
	logic          scr_q;
	logic          esc_out_q;

	// byte path
	logic [CW-1:0] lw_ext;
	logic [CW-1:0] lw_eff;
	logic          need_new;
	logic [RW-1:0] top_n;
	logic [RW-1:0] slot_n;
	logic [RW-1:0] cursor_n;
	logic [LW-1:0] len_n;
	logic [LW-1:0] wcol;
	logic          esc_n;
	logic          stored;
	logic          adv;
	logic          scr;
	logic          we;
	logic [AW-1:0] waddr;

	// read path
	logic [XW-1:0] row_ext;
	logic          row_ok;
	logic [RW-1:0] row_tr;
	logic [RW:0]   rsum;
	logic [RW-1:0] rslot;
	logic [LW-1:0] rlen;
	logic          rvalid;
	logic [AW-1:0] raddr;
	logic          re;
	logic [6:0]    ram_rdata;

	logic          do_byte;

	// take the head transaction when the output register is free or drains
	assign pop     = !q_empty && (!out_valid_q || !out_stall);
	assign do_byte = pop && (it.req == ttw_pkg::REQ_BYTE);
	assign re      = pop && (it.req == ttw_pkg::REQ_READ);

	// effective width, clamped to one .. COLUMNS
	always_comb begin
		lw_ext = CW'(line_width);
		if (lw_ext == '0) begin
			lw_eff = CW'(1);
		end else if (lw_ext > CW'(COLUMNS)) begin
			lw_eff = CW'(COLUMNS);
		end else begin
			lw_eff = lw_ext;
		end
	end

	// received byte: escape tracking, line breaks, append
	always_comb begin
		esc_n    = esc_q;
		top_n    = top_q;
		slot_n   = cur_slot_q;
		cursor_n = cursor_q;
		len_n    = cur_len_q;
		wcol     = cur_len_q;
		need_new = 1'b0;
		stored   = 1'b0;
		adv      = 1'b0;
		scr      = 1'b0;
		we       = 1'b0;
		if (esc_q) begin
			if (it.is_letter) begin
				esc_n = 1'b0;
			end
		end else if (it.is_lbr && (prev_q == ttw_pkg::CH_ESC)) begin
			esc_n = 1'b1;
		end else if (it.is_print || it.is_break) begin
			need_new = (CW'(cur_len_q) >= lw_eff) ||
				(it.is_break && !ttw_pkg::is_break(prev_q));
			if (need_new) begin
				// rows below the cursor are always empty, so the new row starts at zero
				adv    = 1'b1;
				len_n  = '0;
				slot_n = (cur_slot_q == RW'(LINES - 1)) ? '0 : cur_slot_q + 1'b1;
				if (cursor_q == RW'(LINES - 1)) begin
					scr   = 1'b1;
					top_n = (top_q == RW'(LINES - 1)) ? '0 : top_q + 1'b1;
				end else begin
					cursor_n = cursor_q + 1'b1;
				end
			end
			wcol = len_n;
			if (it.is_print && (CW'(len_n) < CW'(COLUMNS))) begin
				we     = 1'b1;
				stored = 1'b1;
				len_n  = len_n + 1'b1;
			end
		end
	end

	assign waddr = AW'(slot_n) * AW'(COLUMNS) + AW'(wcol);

	// cell read: visible row to ring slot, length check
	always_comb begin
		row_ext = XW'(it.read_row);
		row_ok  = (row_ext < XW'(LINES));
		row_tr  = row_ok ? row_ext[RW-1:0] : '0;
		rsum    = {1'b0, top_q} + {1'b0, row_tr};
		if (rsum >= (RW + 1)'(LINES)) begin
			rsum = rsum - (RW + 1)'(LINES);
		end
		rslot  = rsum[RW-1:0];
		rlen   = len_q[rslot];
		rvalid = row_ok && (CW'(it.read_col) < CW'(rlen)) &&
			(CW'(it.read_col) < CW'(COLUMNS));
		raddr  = AW'(rslot) * AW'(COLUMNS) + AW'(it.read_col);
	end

	ttw_ram #(
		.WIDTH(7),
		.DEPTH(LINES * COLUMNS)
	) u_cells (
		.clk  (clk),
		.we   (do_byte && we),
		.waddr(waddr),
		.wdata(it.rx_byte[6:0]),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// state update on each received byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= '0;
			cur_slot_q <= '0;
			cursor_q   <= '0;
			cur_len_q  <= '0;
			esc_q      <= 1'b0;
			prev_q     <= '0;
			for (int i = 0; i < LINES; i++) begin
				len_q[i] <= '0;
			end
		end else if (do_byte) begin
			top_q         <= top_n;
			cur_slot_q    <= slot_n;
			cursor_q      <= cursor_n;
			cur_len_q     <= len_n;
			esc_q         <= esc_n;
			prev_q        <= it.rx_byte;
			len_q[slot_n] <= len_n;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (it.req == ttw_pkg::REQ_READ) begin
				rvalid_q  <= rvalid;
				crow_q    <= 3'(cursor_q);
				clen_q    <= 5'(cur_len_q);
				stored_q  <= 1'b0;
				adv_q     <= 1'b0;
				scr_q     <= 1'b0;
				esc_out_q <= esc_q;
			end else begin
				rvalid_q  <= 1'b0;
				crow_q    <= 3'(cursor_n);
				clen_q    <= 5'(len_n);
				stored_q  <= stored;
				adv_q     <= adv;
				scr_q     <= scr;
				esc_out_q <= esc_n;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign read_valid    = rvalid_q;
	assign read_char     = rvalid_q ? ram_rdata : 7'd0;
	assign cursor_row    = crow_q;
	assign cursor_len    = clen_q;
	assign char_stored   = stored_q;
	assign line_advanced = adv_q;
	assign scrolled      = scr_q;
	assign in_escape     = esc_out_q;

endmodule

`default_nettype wire

// ----- rtl/terminal_text_window.sv -----
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  req_type, rx_byte, read_row, read_col
// out       output     out_valid / out_stall read_char, read_valid, cursor_row, cursor_len,
//                                           char_stored, line_advanced, scrolled, in_escape
// cfg       input      cfg_valid / cfg_ready cfg_data (line width)
//
// one transaction per cycle sustained while out_stall stays low; an accepted transaction is written
// into the queue, then popped by the back as the output register is loaded with its result
// the back unit executes each transaction against the state registers;
// a cell read returns through the registered read port of the cell ram
// reset clears cursor, ring pointer, line lengths and escape state; the cell ram is not cleared
// a two-entry queue absorbs output stalls; in_stall rises when the queue is full

module terminal_text_window #(
	parameter int unsigned LINES   = ttw_pkg::LINES_DEF,
	parameter int unsigned COLUMNS = ttw_pkg::COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       req_type,
	input  wire logic [7:0] rx_byte,
	input  wire logic [2:0] read_row,
	input  wire logic [4:0] read_col,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [6:0]      read_char,
	output logic            read_valid,
	output logic [2:0]      cursor_row,
	output logic [4:0]      cursor_len,
	output logic            char_stored,
	output logic            line_advanced,
	output logic            scrolled,
	output logic            in_escape,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [4:0] cfg_data
);

	ttw_pkg::item_t front_item;
	ttw_pkg::item_t head_item;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic [4:0]     lw_q;

	// line width register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= ttw_pkg::LINE_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			lw_q <= cfg_data;
		end
	end

	// front: classify incoming transactions
	ttw_front u_front (
		.req_type(req_type),
		.rx_byte (rx_byte),
		.read_row(read_row),
		.read_col(read_col),
		.item    (front_item)
	);

	assign in_stall = q_full;

	ttw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_item)
	);

	// back: window state, cell ram and output register
	ttw_back #(
		.LINES  (LINES),
		.COLUMNS(COLUMNS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_width   (lw_q),
		.q_empty      (q_empty),
		.it           (head_item),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_char    (read_char),
		.read_valid   (read_valid),
		.cursor_row   (cursor_row),
		.cursor_len   (cursor_len),
		.char_stored  (char_stored),
		.line_advanced(line_advanced),
		.scrolled     (scrolled),
		.in_escape    (in_escape)
	);

	// an invalid cell reads as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_char == 7'd0)
		else $error("invalid cell read returned a non-zero character");

	// scrolling only happens on a line advance from the bottom row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> line_advanced && (cursor_row == 3'(LINES - 1)))
		else $error("scroll without line advance on the bottom row");

	// a stored character means the escape sequence is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_stored |-> !in_escape && !read_valid)
		else $error("character stored while in escape or on a read");

	// reads never alter the window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !char_stored && !line_advanced && !scrolled)
		else $error("cell read reported a window change");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import ttw_pkg::*;

	localparam int ROWS = LINES_DEF;
	localparam int COLS = COLUMNS_DEF;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 210;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// one input transaction
	typedef struct packed {
		req_t       req;
		logic [7:0] data;
		logic [2:0] row;
		logic [4:0] col;
	} window_req_t;

	// one result transaction, in port order
	typedef struct packed {
		logic [6:0] ch;
		logic       vld;
		logic [2:0] row;
		logic [4:0] len;
		logic       stored;
		logic       adv;
		logic       scr;
		logic       esc;
	} window_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       req_type = 1'b0;
	logic [7:0] rx_byte = '0;
	logic [2:0] read_row = '0;
	logic [4:0] read_col = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] read_char;
	logic       read_valid;
	logic [2:0] cursor_row;
	logic [4:0] cursor_len;
	logic       char_stored;
	logic       line_advanced;
	logic       scrolled;
	logic       in_escape;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;

	terminal_text_window #(
		.LINES(ROWS),
		.COLUMNS(COLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.read_row(read_row),
		.read_col(read_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_char(read_char),
		.read_valid(read_valid),
		.cursor_row(cursor_row),
		.cursor_len(cursor_len),
		.char_stored(char_stored),
		.line_advanced(line_advanced),
		.scrolled(scrolled),
		.in_escape(in_escape),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// window shadow state
	logic [6:0]     cell_mem [ROWS*COLS];
	int             line_len [ROWS];
	int             cur_line = 0;
	int             top_slot = 0;
	bit             esc_open = 1'b0;
	logic [7:0]     prev_byte = '0;
	logic [4:0]     width_reg = LINE_WIDTH_RST;

	window_req_t    pending [$];
	window_result_t window_expected [$];
	window_req_t    in_item;
	bit             idle_on = 1'b1;
	bit             hold_tog = 1'b0;
	bit             hold_seen = 1'b0;
	int             hold_left = 0;
	int             stall_left = 0;
	int             src_gap = 0;
	int             quiet_cycles = 0;
	int             errors = 0;
	int             total_added = 0;

	initial begin
		foreach (line_len[i])
			line_len[i] = 0;
	end

	function automatic bit crlf(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	// advance the shadow window by one transaction and return its result
	function automatic window_result_t window_step(input window_req_t it);
		window_result_t r;
		int             s;
		int             w;
		bit             need;
		logic [7:0]     b;
		r = '0;
		b = it.data;
		if (it.req == REQ_READ) begin
			if (it.row < ROWS) begin
				s = (top_slot + it.row) % ROWS;
				if (it.col < line_len[s]) begin
					r.vld = 1'b1;
					r.ch = cell_mem[s*COLS + it.col];
				end
			end
		end else begin
			if (esc_open) begin
				// any letter closes the sequence
				if (((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z)))
					esc_open = 1'b0;
			end else if ((b == CH_LBR) && (prev_byte == CH_ESC)) begin
				esc_open = 1'b1;
			end else if (((b >= CH_SPACE) && (b <= CH_TILDE)) || crlf(b)) begin
				w = int'(width_reg);
				if (w < 1)
					w = 1;
				if (w > COLS)
					w = COLS;
				s = (top_slot + cur_line) % ROWS;
				need = line_len[s] >= w;
				if (!need && crlf(b) && !crlf(prev_byte))
					need = 1'b1;
				// new line: move down or scroll the ring
				if (need) begin
					r.adv = 1'b1;
					if (cur_line + 1 < ROWS) begin
						cur_line++;
					end else begin
						r.scr = 1'b1;
						top_slot = (top_slot + 1) % ROWS;
						line_len[(top_slot + cur_line) % ROWS] = 0;
					end
				end
				if (!crlf(b)) begin
					s = (top_slot + cur_line) % ROWS;
					if (line_len[s] < COLS) begin
						cell_mem[s*COLS + line_len[s]] = b[6:0];
						line_len[s]++;
						r.stored = 1'b1;
					end
				end
			end
			prev_byte = b;
		end
		r.row = cur_line[2:0];
		r.len = 5'(line_len[(top_slot + cur_line) % ROWS]);
		r.esc = esc_open;
		return r;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		pending.push_back('{REQ_BYTE, b, 3'($urandom), 5'($urandom)});
		total_added++;
	endfunction

	function automatic void add_read(input logic [2:0] r, input logic [4:0] c);
		pending.push_back('{REQ_READ, 8'($urandom), r, c});
		total_added++;
	endfunction

	// sender: predicts on acceptance, holds while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				window_expected.push_back(window_step(in_item));
			if (!(in_valid && in_stall)) begin
				if ((src_gap == 0) && idle_on && ($urandom_range(0, 7) == 0))
					src_gap = $urandom_range(1, 8);
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_item = pending.pop_front();
					req_type <= in_item.req;
					rx_byte <= in_item.data;
					read_row <= in_item.row;
					read_col <= in_item.col;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: one long hold on request, random bursts otherwise
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		window_result_t got;
		window_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {read_char, read_valid, cursor_row, cursor_len,
				char_stored, line_advanced, scrolled, in_escape};
			if (window_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = window_expected.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch expected: char=%h vld=%b row=%0d len=%0d st=%b adv=%b scr=%b esc=%b",
							want.ch, want.vld, want.row, want.len,
							want.stored, want.adv, want.scr, want.esc);
						$display("         actual:   char=%h vld=%b row=%0d len=%0d st=%b adv=%b scr=%b esc=%b",
							got.ch, got.vld, got.row, got.len,
							got.stored, got.adv, got.scr, got.esc);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("terminal_text_window test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// wait for all results, then let the pipeline settle
	task automatic wait_drained;
		do
			@(negedge clk);
		while ((pending.size() != 0) || in_valid || (window_expected.size() != 0));
		repeat (4) @(negedge clk);
	endtask

	// stimulus and phase control
	initial begin
		logic [4:0] width_plan [PHASES];
		int         start_cnt;
		int         pick;
		int         letter;
		width_plan = '{5'd1, 5'd0, 5'd21, 5'd31, 5'd4, 5'd22, 5'd2, 5'd13, 5'd0};
		width_plan[PHASES-1] = 5'($urandom_range(0, 31));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty window, bounds, ignored bytes, line breaks, escapes
		add_read(3'd0, 5'd0);
		add_read(3'd7, 5'd31);
		add_byte(CH_SPACE);
		add_byte(CH_TILDE);
		add_byte(8'h7F);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_byte(CH_CR);
		add_byte(CH_LF);
		add_byte(CH_CR);
		add_byte(CH_UP_A);
		add_byte(CH_ESC);
		add_byte(CH_LBR);
		add_byte(CH_ZERO + 8'd1);
		add_byte(CH_LO_A + 8'd12);
		add_byte(CH_ESC);
		add_byte(CH_UP_Z - 8'd2);
		add_read(3'd0, 5'd1);
		add_read(3'd1, 5'd1);
		add_read(3'd1, 5'd20);
		add_read(3'd5, 5'd0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			// width update while idle
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= width_plan[p];
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid <= 1'b0;
			width_reg = width_plan[p];
			@(negedge clk);
			idle_on = (p != 4) && (p != PHASES - 1);

			// random traffic, mostly text, breaks, escapes and reads
			start_cnt = total_added;
			while (total_added - start_cnt < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					repeat ($urandom_range(1, 25))
						add_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
				end else if (pick < 52) begin
					repeat ($urandom_range(1, 3))
						add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				end else if (pick < 62) begin
					add_byte(CH_ESC);
					add_byte(CH_LBR);
					repeat ($urandom_range(0, 3))
						add_byte($urandom_range(0, 3) == 0 ? CH_SEMI :
							CH_ZERO + 8'($urandom_range(0, 9)));
					letter = $urandom_range(0, 25);
					add_byte(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(letter));
				end else if (pick < 87) begin
					repeat ($urandom_range(1, 4))
						add_read(3'($urandom_range(0, 9) == 0 ? $urandom_range(6, 7) :
							$urandom_range(0, 5)),
							5'($urandom_range(0, 9) == 0 ? $urandom_range(21, 31) :
							$urandom_range(0, 20)));
				end else if (pick < 95) begin
					add_byte(8'($urandom_range(0, 255)));
				end else begin
					// broken sequence: escape followed by anything
					add_byte(CH_ESC);
					add_byte(8'($urandom_range(0, 255)));
				end
			end

			// long receiver hold while the sender keeps offering
			if (p == 3) begin
				@(posedge clk);
				hold_tog <= ~hold_tog;
			end
		end

		wait_drained();
		errors += window_expected.size();
		if (errors == 0)
			$display("terminal_text_window test passed");
		else
			$display("terminal_text_window test failed");
		$finish;
	end

endmodule
